>>> rtl/tet_shape_gradient_volume_macros.svh
// Assertion macros for the tetrahedron gradient block
`ifndef TET_SHAPE_GRADIENT_VOLUME_MACROS_SVH
`define TET_SHAPE_GRADIENT_VOLUME_MACROS_SVH
// property must hold on every edge out of reset
`define TSG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define TSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/tsg_pkg.sv
package tsg_pkg;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int GRAD_SHIFT = 24;
	localparam int NUM_CORNERS = 4;
	localparam int CORNER_W = 2;
	localparam int GRAD_W = 32;
	localparam int VOL_W = 52;
	localparam int IN_W = 16;
	// dividend magnitude width: cofactor (<= 2*(w+1)+2 bits) shifted by 24
	localparam int NUM_W = 2 * (COORD_WIDTH_DEF + 1) + 2 + GRAD_SHIFT;
	localparam int DEN_W = 3 * (COORD_WIDTH_DEF + 1) + 2;
	localparam int QUOT_W = 34;

	typedef enum logic [1:0] {
		SGN_NONE = 2'd0,
		SGN_POS  = 2'd1,
		SGN_NEG  = 2'd2,
		SGN_RSVD = 2'd3
	} sgn_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DET,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [IN_W-1:0] node0_x;
		logic signed [IN_W-1:0] node0_y;
		logic signed [IN_W-1:0] node0_z;
		logic signed [IN_W-1:0] node1_x;
		logic signed [IN_W-1:0] node1_y;
		logic signed [IN_W-1:0] node1_z;
		logic signed [IN_W-1:0] node2_x;
		logic signed [IN_W-1:0] node2_y;
		logic signed [IN_W-1:0] node2_z;
		logic signed [IN_W-1:0] node3_x;
		logic signed [IN_W-1:0] node3_y;
		logic signed [IN_W-1:0] node3_z;
	} in_word_t;

	typedef struct packed {
		logic [CORNER_W-1:0]      corner;
		logic signed [GRAD_W-1:0] grad_x;
		logic signed [GRAD_W-1:0] grad_y;
		logic signed [GRAD_W-1:0] grad_z;
		logic [VOL_W-1:0]         volume;
		logic                     inverted;
		logic                     degenerate;
		logic                     last;
	} out_word_t;

	// lane control from sequencer
	typedef struct packed {
		logic start;
		logic neg;
		logic zero_num;
		logic zero_den;
		logic num_pos;
	} lane_ctl_t;
endpackage

>>> rtl/tsg_div_lane.sv
// Restoring divider lane: one quotient bit per cycle, saturated to Q16.16.
module tsg_div_lane #(
	parameter int NUM_W = tsg_pkg::NUM_W,
	parameter int DEN_W = tsg_pkg::DEN_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsg_pkg::lane_ctl_t          ctl,
	input  logic [NUM_W-1:0]            num_mag,
	input  logic [DEN_W-1:0]            den_mag,
	output logic                        done,
	output logic signed [tsg_pkg::GRAD_W-1:0] grad
);
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int QW = tsg_pkg::QUOT_W;
	logic [NUM_W-1:0]  n_q;
	logic [DEN_W:0]    r_q;
	logic [QW-1:0]     q_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	tsg_pkg::lane_ctl_t c_q;
	logic [DEN_W:0]    r_sh;
	logic              ge;
	logic [QW-1:0]     q_nx;

	assign r_sh = {r_q[DEN_W-1:0], n_q[NUM_W-1]};
	assign ge   = r_sh >= {1'b0, den_mag};
	always_comb begin
		q_nx = {q_q[QW-2:0], ge};
		// cap keeps the quotient above any saturation threshold
		if (q_q[QW-1] | q_q[QW-2]) q_nx = {2'b01, {(QW-2){1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			n_q <= num_mag;
			r_q <= '0;
			q_q <= '0;
			c_q <= ctl;
		end else if (busy_q) begin
			n_q <= {n_q[NUM_W-2:0], 1'b0};
			r_q <= ge ? r_sh - {1'b0, den_mag} : r_sh;
			q_q <= q_nx;
		end
	end

	assign done = !busy_q;

	always_comb begin
		if (c_q.zero_den) begin
			if (c_q.zero_num)     grad = '0;
			else if (c_q.num_pos) grad = 32'sh7FFF_FFFF;
			else                  grad = 32'sh8000_0000;
		end else if (c_q.neg) begin
			if (q_q > QW'(33'h0_8000_0000)) grad = 32'sh8000_0000;
			else grad = 32'(-q_q);
		end else begin
			if (q_q > QW'(33'h0_7FFF_FFFF)) grad = 32'sh7FFF_FFFF;
			else grad = 32'(q_q);
		end
	end
endmodule

>>> rtl/tsg_geom.sv
// Edge matrix, cofactors and determinant, two registered stages.
module tsg_geom #(
	parameter int COORD_WIDTH = tsg_pkg::COORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  tsg_pkg::in_word_t    in_w,
	output logic signed [2*(COORD_WIDTH+1)+2:0] cof [4][3],
	output logic signed [3*(COORD_WIDTH+1)+2:0] det
);
	localparam int EW = COORD_WIDTH + 1;
	localparam int CW = 2 * EW + 3;
	localparam int DW = 3 * EW + 3;
	logic signed [COORD_WIDTH-1:0] p [4][3];
	logic signed [EW-1:0] j_s1 [3][3];
	logic signed [CW-1:0] c_s2 [4][3];
	logic signed [EW-1:0] j_s2 [3];
	logic signed [DW-1:0] dp [3];

	// only the low COORD_WIDTH bits of a coordinate count
	always_comb begin
		p[0][0] = COORD_WIDTH'(in_w.node0_x); p[0][1] = COORD_WIDTH'(in_w.node0_y);
		p[0][2] = COORD_WIDTH'(in_w.node0_z); p[1][0] = COORD_WIDTH'(in_w.node1_x);
		p[1][1] = COORD_WIDTH'(in_w.node1_y); p[1][2] = COORD_WIDTH'(in_w.node1_z);
		p[2][0] = COORD_WIDTH'(in_w.node2_x); p[2][1] = COORD_WIDTH'(in_w.node2_y);
		p[2][2] = COORD_WIDTH'(in_w.node2_z); p[3][0] = COORD_WIDTH'(in_w.node3_x);
		p[3][1] = COORD_WIDTH'(in_w.node3_y); p[3][2] = COORD_WIDTH'(in_w.node3_z);
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				j_s1[r][k] <= EW'(p[r+1][k]) - EW'(p[0][k]);
	end

	function automatic logic signed [CW-1:0] cf(logic signed [EW-1:0] a, logic signed [EW-1:0] b,
		logic signed [EW-1:0] c, logic signed [EW-1:0] d);
		logic signed [2*EW-1:0] ab;
		logic signed [2*EW-1:0] cd;
		ab = a * b;
		cd = c * d;
		cf = CW'(ab) - CW'(cd);
	endfunction

	always_ff @(posedge clk) begin
		c_s2[1][0] <= cf(j_s1[2][2], j_s1[1][1], j_s1[2][1], j_s1[1][2]);
		c_s2[2][0] <= cf(j_s1[2][1], j_s1[0][2], j_s1[2][2], j_s1[0][1]);
		c_s2[3][0] <= cf(j_s1[1][2], j_s1[0][1], j_s1[1][1], j_s1[0][2]);
		c_s2[1][1] <= cf(j_s1[2][0], j_s1[1][2], j_s1[2][2], j_s1[1][0]);
		c_s2[2][1] <= cf(j_s1[2][2], j_s1[0][0], j_s1[2][0], j_s1[0][2]);
		c_s2[3][1] <= cf(j_s1[1][0], j_s1[0][2], j_s1[1][2], j_s1[0][0]);
		c_s2[1][2] <= cf(j_s1[2][1], j_s1[1][0], j_s1[2][0], j_s1[1][1]);
		c_s2[2][2] <= cf(j_s1[2][0], j_s1[0][1], j_s1[2][1], j_s1[0][0]);
		c_s2[3][2] <= cf(j_s1[1][1], j_s1[0][0], j_s1[1][0], j_s1[0][1]);
		for (int r = 0; r < 3; r++) j_s2[r] <= j_s1[r][0];
	end

	always_comb begin
		for (int i = 1; i < 4; i++)
			for (int k = 0; k < 3; k++) cof[i][k] = c_s2[i][k];
		for (int k = 0; k < 3; k++)
			cof[0][k] = -(c_s2[1][k] + c_s2[2][k] + c_s2[3][k]);
	end

	// full-width products, registered by the top level before use
	always_comb begin
		for (int r = 0; r < 3; r++) dp[r] = j_s2[r] * c_s2[r+1][0];
	end
	assign det = dp[0] + dp[1] + dp[2];
endmodule

>>> rtl/tet_shape_gradient_volume.sv
// Linear tetrahedron shape gradients and volume. One input word carries the
// four corners (signed Q8.8); four output words follow, corner 0 to 3, each
// with the Q16.16 x/y/z gradients and the Q24 volume |det|/6. The edge matrix,
// cofactors and registered determinant come first, then twelve divider lanes
// run in parallel, one quotient bit a cycle; the dividend is 2*COORD_WIDTH+29
// bits wide, 61 at the default. A new input word is taken only once all four
// output words have left: idle, geometry, divide and output run in order and
// one item is in flight at a time. The divider sets the rate. The volume
// divide by six runs as a shift-add chain beside the lanes and is ready long
// before them.
// A sign flip against the last element not marked inverted marks the element
// inverted: gradients are zero, the stored volume is repeated. A zero det
// marks it degenerate: gradients saturate, but are zero for a zero cofactor.
module tet_shape_gradient_volume #(
	parameter int COORD_WIDTH = tsg_pkg::COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsg_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tsg_pkg::out_word_t  out_data
);
`include "tet_shape_gradient_volume_macros.svh"
	localparam int EW = COORD_WIDTH + 1;
	localparam int CW = 2 * EW + 3;
	localparam int DW = 3 * EW + 3;
	localparam int NW = CW + tsg_pkg::GRAD_SHIFT;
	localparam int VW = tsg_pkg::VOL_W;

	tsg_pkg::state_t st_q, st_nx;
	logic [1:0] wait_q;
	logic [1:0] corner_q;
	tsg_pkg::in_word_t in_q;
	logic signed [CW-1:0] cof [4][3];
	logic signed [DW-1:0] det_c, det_q;
	logic [DW-1:0] dmag;
	logic [1:0] sgn_q;
	logic [VW-1:0] prev_vol_q, vol_q;
	logic inv_q, deg_q;
	logic start;
	logic fin;
	logic [3:0][2:0] lane_done;
	logic signed [tsg_pkg::GRAD_W-1:0] grad [4][3];
	logic all_done;
	logic [1:0] sgn_new;
	logic inv_c;
	logic [DW-1:0] vdiv;
	logic [VW-1:0] vsat;
	// divide-by-three chain on |det|/2
	logic [DW-1:0] vx_q, v0_q, v1_q, v2_q, v3_q, v4_q, vr_q;
	logic [9:0] vfix;

	tsg_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
		.clk(clk), .in_w(in_q), .cof(cof), .det(det_c));

	assign dmag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
	assign sgn_new = (det_q == '0) ? tsg_pkg::SGN_NONE
		: (det_q[DW-1] ? tsg_pkg::SGN_NEG : tsg_pkg::SGN_POS);
	assign inv_c = (sgn_q == tsg_pkg::SGN_POS && sgn_new == tsg_pkg::SGN_NEG)
		|| (sgn_q == tsg_pkg::SGN_NEG && sgn_new == tsg_pkg::SGN_POS);
	assign start = (st_q == tsg_pkg::ST_DET) && (wait_q == 2'd3);
	assign fin = (st_q == tsg_pkg::ST_DIV) && all_done;

	// floor(|det|/6) = floor((|det|>>1)/3); the series underestimates by a few
	// units, the remainder (< 32) is fixed up with 11*r>>5
	assign vfix = 10'(vr_q[5:0]) * 10'd11;
	assign vdiv = v4_q + DW'(vfix[9:5]);
	assign vsat = (vdiv > DW'({VW{1'b1}})) ? {VW{1'b1}} : VW'(vdiv);

	for (genvar i = 0; i < 4; i++) begin : g_corner
		for (genvar k = 0; k < 3; k++) begin : g_axis
			tsg_pkg::lane_ctl_t lc;
			logic [CW-1:0] nm;
			logic signed [tsg_pkg::GRAD_W-1:0] gl;
			assign nm = cof[i][k][CW-1] ? CW'(-cof[i][k]) : CW'(cof[i][k]);
			assign lc.start = start;
			assign lc.neg = cof[i][k][CW-1] ^ det_q[DW-1];
			assign lc.zero_num = cof[i][k] == '0;
			assign lc.zero_den = det_q == '0;
			assign lc.num_pos = !cof[i][k][CW-1];
			tsg_div_lane #(.NUM_W(NW), .DEN_W(DW)) u_lane (
				.clk(clk), .arst_n(arst_n), .ctl(lc),
				.num_mag({nm, {tsg_pkg::GRAD_SHIFT{1'b0}}}),
				.den_mag(dmag), .done(lane_done[i][k]), .grad(gl));
			assign grad[i][k] = gl;
		end
	end
	assign all_done = &lane_done;

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			tsg_pkg::ST_IDLE: if (in_valid) st_nx = tsg_pkg::ST_DET;
			tsg_pkg::ST_DET:  if (wait_q == 2'd3) st_nx = tsg_pkg::ST_DIV;
			tsg_pkg::ST_DIV:  if (all_done) st_nx = tsg_pkg::ST_OUT;
			tsg_pkg::ST_OUT:  if (out_ready && corner_q == 2'd3) st_nx = tsg_pkg::ST_IDLE;
			default:          st_nx = tsg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = st_q == tsg_pkg::ST_IDLE;
		out_valid = st_q == tsg_pkg::ST_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= tsg_pkg::ST_IDLE;
			wait_q     <= '0;
			corner_q   <= '0;
			sgn_q      <= tsg_pkg::SGN_NONE;
			prev_vol_q <= '0;
		end else begin
			st_q <= st_nx;
			if (st_q == tsg_pkg::ST_DET) wait_q <= wait_q + 1'b1;
			else wait_q <= '0;
			if (start && !inv_c) sgn_q <= sgn_new;
			if (fin && !inv_q) prev_vol_q <= vsat;
			if (st_q == tsg_pkg::ST_OUT && out_ready) corner_q <= corner_q + 1'b1;
		end
	end

	// det is registered in the cycle after the cofactors settle
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) in_q <= in_data;
		if (st_q == tsg_pkg::ST_DET && wait_q == 2'd2) det_q <= det_c;
		if (start) begin
			inv_q <= inv_c;
			deg_q <= !inv_c && det_q == '0;
		end
		if (fin) vol_q <= inv_q ? prev_vol_q : vsat;
	end

	// free running; dmag holds from the start cycle, settles through the vx, v0-v4 and vr registers
	always_ff @(posedge clk) begin
		vx_q <= dmag >> 1;
		v0_q <= (vx_q >> 2) + (vx_q >> 4);
		v1_q <= v0_q + (v0_q >> 4);
		v2_q <= v1_q + (v1_q >> 8);
		v3_q <= v2_q + (v2_q >> 16);
		v4_q <= v3_q + (v3_q >> 32);
		vr_q <= vx_q - (v4_q + (v4_q << 1));
	end

	always_comb begin
		out_data.corner     = corner_q;
		out_data.grad_x     = inv_q ? '0 : grad[corner_q][0];
		out_data.grad_y     = inv_q ? '0 : grad[corner_q][1];
		out_data.grad_z     = inv_q ? '0 : grad[corner_q][2];
		out_data.volume     = vol_q;
		out_data.inverted   = inv_q;
		out_data.degenerate = deg_q;
		out_data.last       = corner_q == 2'd3;
	end

	`TSG_ASSERT(a_one_side, !(in_ready && out_valid), "input and output open together")
	`TSG_ASSERT_NEXT(a_last_idle, out_valid && out_ready && out_data.last, in_ready,
		"block not idle after last word")
	`TSG_ASSERT(a_flags, !(out_valid && out_data.inverted && out_data.degenerate),
		"inverted and degenerate together")
endmodule
